@@ hdl/pmpt_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the promotable max priority table
// no dependencies

package pmpt_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int VALUE_BITS_DEF    = 32;
    localparam int PRIORITY_BITS_DEF = 16;

    // fixed widths of the stream fields
    localparam int ID_W    = 6;
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 16;

    typedef enum logic [2:0] {
        CMD_ADD     = 3'd0,
        CMD_PROMOTE = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_POP     = 3'd3,
        CMD_LOOKUP  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOT_LIVE = 2'd3
    } status_t;

    // command broadcast from the control to every cell
    typedef struct packed {
        cmd_t cmd;
        logic id_ok;   // item id is below capacity
        logic add_ok;  // an unused id is still left
    } req_t;

endpackage

@@ hdl/pmpt_cell.sv @@
`timescale 1ns / 1ps
// one table entry: value, priority and live mark, plus one stage of the scan token
// depends on pmpt_pkg

module pmpt_cell #(
    parameter int CAPACITY      = pmpt_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = pmpt_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = pmpt_pkg::PRIORITY_BITS_DEF,
    parameter int IDX           = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pmpt_pkg::req_t               req,
    input  logic [$clog2(CAPACITY)-1:0]  id_idx,
    input  logic [$clog2(CAPACITY)-1:0]  add_idx,
    input  logic [VALUE_BITS-1:0]        add_value,
    input  logic                         kill,
    input  logic [$clog2(CAPACITY)-1:0]  kill_idx,
    input  logic                         tok_valid_in,
    input  logic                         tok_found_in,
    input  logic [$clog2(CAPACITY)-1:0]  tok_idx_in,
    input  logic [VALUE_BITS-1:0]        tok_value_in,
    input  logic [PRIORITY_BITS-1:0]     tok_prio_in,
    output logic                         tok_valid_out,
    output logic                         tok_found_out,
    output logic [$clog2(CAPACITY)-1:0]  tok_idx_out,
    output logic [VALUE_BITS-1:0]        tok_value_out,
    output logic [PRIORITY_BITS-1:0]     tok_prio_out
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                     live_reg;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;

    logic                     tok_valid_reg;
    logic                     tok_found_reg;
    logic [IW-1:0]            tok_idx_reg;
    logic [VALUE_BITS-1:0]    tok_value_reg;
    logic [PRIORITY_BITS-1:0] tok_prio_reg;

    logic                     tok_found_next;
    logic [IW-1:0]            tok_idx_next;
    logic [VALUE_BITS-1:0]    tok_value_next;
    logic [PRIORITY_BITS-1:0] tok_prio_next;
    logic                     do_add;
    logic                     do_promote;
    logic                     id_hit;
    logic [PRIORITY_BITS-1:0] prio_inc;

    assign id_hit   = req.id_ok && (id_idx == MY_IDX) && live_reg;
    assign prio_inc = (prio_reg == {PRIORITY_BITS{1'b1}}) ? prio_reg
                                                          : prio_reg + 1'b1;

    always_comb begin
        tok_found_next = tok_found_in;
        tok_idx_next   = tok_idx_in;
        tok_value_next = tok_value_in;
        tok_prio_next  = tok_prio_in;
        do_add         = 1'b0;
        do_promote     = 1'b0;
        if (tok_valid_in) begin
            case (req.cmd)
                pmpt_pkg::CMD_ADD: begin
                    if (req.add_ok && add_idx == MY_IDX) begin
                        do_add         = 1'b1;
                        tok_found_next = 1'b1;
                        tok_idx_next   = MY_IDX;
                        tok_value_next = add_value;
                        tok_prio_next  = '0;
                    end
                end
                pmpt_pkg::CMD_PROMOTE: begin
                    if (id_hit) begin
                        do_promote     = 1'b1;
                        tok_found_next = 1'b1;
                        tok_idx_next   = MY_IDX;
                        tok_value_next = value_reg;
                        tok_prio_next  = prio_inc;
                    end
                end
                pmpt_pkg::CMD_LOOKUP: begin
                    if (id_hit) begin
                        tok_found_next = 1'b1;
                        tok_idx_next   = MY_IDX;
                        tok_value_next = value_reg;
                        tok_prio_next  = prio_reg;
                    end
                end
                pmpt_pkg::CMD_PEEK, pmpt_pkg::CMD_POP: begin
                    // later index wins ties, so take on equal priority
                    if (live_reg && (!tok_found_in || prio_reg >= tok_prio_in)) begin
                        tok_found_next = 1'b1;
                        tok_idx_next   = MY_IDX;
                        tok_value_next = value_reg;
                        tok_prio_next  = prio_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid_in;
            if (do_add) begin
                live_reg <= 1'b1;
            end else if (kill && kill_idx == MY_IDX) begin
                live_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_add) begin
            value_reg <= add_value;
            prio_reg  <= '0;
        end else if (do_promote) begin
            prio_reg <= prio_inc;
        end
        tok_found_reg <= tok_found_next;
        tok_idx_reg   <= tok_idx_next;
        tok_value_reg <= tok_value_next;
        tok_prio_reg  <= tok_prio_next;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_found_out = tok_found_reg;
    assign tok_idx_out   = tok_idx_reg;
    assign tok_value_out = tok_value_reg;
    assign tok_prio_out  = tok_prio_reg;

endmodule

@@ hdl/promotable_max_priority_table.sv @@
`timescale 1ns / 1ps
// promotable max priority table: the accepted word is registered, the scan token walks the cell
// chain one cell per cycle, the result goes to a hold register, then to the output register; a new
// word is taken only once the result has left the hold register; every command takes that walk
// reset (aresetn low, synchronous) clears all live marks, the id counter and both
// handshakes at once; no clearing pass, values and priorities stay unwritten until add
// depends on pmpt_pkg and pmpt_cell

module promotable_max_priority_table #(
    parameter int CAPACITY      = pmpt_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS    = pmpt_pkg::VALUE_BITS_DEF,
    parameter int PRIORITY_BITS = pmpt_pkg::PRIORITY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // item_id[5:0], item_value[37:6], zero pad
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_id[5:0], result_value[37:6], result_priority[53:38]
    output logic [2:0]  m_tuser    // present[0], status[2:1]
);

    localparam int IW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // command held steady while the token walks the chain
    pmpt_pkg::cmd_t          cmd_reg;
    logic [IW-1:0]           id_idx_reg;
    logic                    id_ok_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic                    start_reg;
    logic [NW-1:0]           next_free_reg;

    // finished result waiting for the output register
    logic [pmpt_pkg::ID_W-1:0]    hold_id_reg;
    logic [pmpt_pkg::VALUE_W-1:0] hold_value_reg;
    logic [pmpt_pkg::PRIO_W-1:0]  hold_prio_reg;
    logic                         hold_present_reg;
    pmpt_pkg::status_t            hold_status_reg;

    logic                         m_tvalid_reg;
    logic [pmpt_pkg::ID_W-1:0]    m_id_reg;
    logic [pmpt_pkg::VALUE_W-1:0] m_value_reg;
    logic [pmpt_pkg::PRIO_W-1:0]  m_prio_reg;
    logic                         m_present_reg;
    pmpt_pkg::status_t            m_status_reg;

    pmpt_pkg::req_t req;
    logic           accept;
    logic           tail_hit;
    logic           kill;
    logic           out_free;

    // input field views
    logic [63:0] in_value_wide;
    logic [31:0] in_id_wide;

    // scan token chain, slot 0 is the injection point
    logic [CAPACITY:0]        tok_valid;
    logic [CAPACITY:0]        tok_found;
    logic [IW-1:0]            tok_idx   [CAPACITY+1];
    logic [VALUE_BITS-1:0]    tok_value [CAPACITY+1];
    logic [PRIORITY_BITS-1:0] tok_prio  [CAPACITY+1];

    // result field views
    logic [15:0] tail_idx_wide;
    logic [63:0] tail_value_wide;
    logic [31:0] tail_prio_wide;
    pmpt_pkg::status_t tail_status;
    logic              tail_present;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_value_wide = 64'(s_tdata[37:6]);
    assign in_id_wide    = 32'(s_tdata[5:0]);

    assign req.cmd    = cmd_reg;
    assign req.id_ok  = id_ok_reg;
    assign req.add_ok = (next_free_reg < NW'(CAPACITY));

    assign tok_valid[0] = start_reg;
    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_value[0] = '0;
    assign tok_prio[0]  = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            pmpt_cell #(
                .CAPACITY      (CAPACITY),
                .VALUE_BITS    (VALUE_BITS),
                .PRIORITY_BITS (PRIORITY_BITS),
                .IDX           (gi)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .req           (req),
                .id_idx        (id_idx_reg),
                .add_idx       (next_free_reg[IW-1:0]),
                .add_value     (value_reg),
                .kill          (kill),
                .kill_idx      (tok_idx[CAPACITY]),
                .tok_valid_in  (tok_valid[gi]),
                .tok_found_in  (tok_found[gi]),
                .tok_idx_in    (tok_idx[gi]),
                .tok_value_in  (tok_value[gi]),
                .tok_prio_in   (tok_prio[gi]),
                .tok_valid_out (tok_valid[gi+1]),
                .tok_found_out (tok_found[gi+1]),
                .tok_idx_out   (tok_idx[gi+1]),
                .tok_value_out (tok_value[gi+1]),
                .tok_prio_out  (tok_prio[gi+1])
            );
        end
    endgenerate

    // token leaving the last cell carries the whole answer
    assign tail_hit = (state_reg == S_SCAN) && tok_valid[CAPACITY];
    // pop removes the winner as the token comes out
    assign kill     = tail_hit && (cmd_reg == pmpt_pkg::CMD_POP) && tok_found[CAPACITY];

    assign tail_idx_wide   = 16'(tok_idx[CAPACITY]);
    assign tail_value_wide = 64'(tok_value[CAPACITY]);
    assign tail_prio_wide  = 32'(tok_prio[CAPACITY]);
    assign tail_present    = (cmd_reg == pmpt_pkg::CMD_LOOKUP) && tok_found[CAPACITY];

    always_comb begin
        case (cmd_reg)
            pmpt_pkg::CMD_ADD:
                tail_status = tok_found[CAPACITY] ? pmpt_pkg::ST_OK : pmpt_pkg::ST_FULL;
            pmpt_pkg::CMD_PROMOTE, pmpt_pkg::CMD_LOOKUP:
                tail_status = tok_found[CAPACITY] ? pmpt_pkg::ST_OK : pmpt_pkg::ST_NOT_LIVE;
            pmpt_pkg::CMD_PEEK, pmpt_pkg::CMD_POP:
                tail_status = tok_found[CAPACITY] ? pmpt_pkg::ST_OK : pmpt_pkg::ST_EMPTY;
            default:
                tail_status = pmpt_pkg::ST_OK;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tail_hit) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            next_free_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
            if (tail_hit && cmd_reg == pmpt_pkg::CMD_ADD && tok_found[CAPACITY]) begin
                next_free_reg <= next_free_reg + 1'b1;
            end
            if (state_reg == S_FIN && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg    <= pmpt_pkg::cmd_t'(s_tuser);
            id_idx_reg <= IW'(s_tdata[5:0]);
            id_ok_reg  <= (in_id_wide < 32'(CAPACITY));
            value_reg  <= in_value_wide[VALUE_BITS-1:0];
        end
        if (tail_hit) begin
            hold_id_reg      <= tail_idx_wide[pmpt_pkg::ID_W-1:0];
            hold_value_reg   <= tail_value_wide[pmpt_pkg::VALUE_W-1:0];
            hold_prio_reg    <= tail_prio_wide[pmpt_pkg::PRIO_W-1:0];
            hold_present_reg <= tail_present;
            hold_status_reg  <= tail_status;
        end
        if (state_reg == S_FIN && out_free) begin
            m_id_reg      <= hold_id_reg;
            m_value_reg   <= hold_value_reg;
            m_prio_reg    <= hold_prio_reg;
            m_present_reg <= hold_present_reg;
            m_status_reg  <= hold_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_prio_reg, m_value_reg, m_id_reg};
    assign m_tuser  = {m_status_reg, m_present_reg};

    // no token may be in the chain while a new word can come in
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (tok_valid == '0))
        else $error("token in flight while idle");

    // at most one token walks the chain
    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid) <= 1)
        else $error("more than one scan token");

    // the token only leaves the chain during a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        tok_valid[CAPACITY] |-> (state_reg == S_SCAN))
        else $error("token exit outside scan");

    // id counter never runs past the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |-> (next_free_reg <= NW'(CAPACITY)))
        else $error("id counter beyond capacity");

    // a present flag only comes with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_present_reg) |-> (m_status_reg == pmpt_pkg::ST_OK))
        else $error("present with failing status");

endmodule

@@ test/promotable_max_priority_table_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for promotable_max_priority_table: directed and random command words
// with a scoreboard that keeps its own copy of the table; depends on pmpt_pkg and the dut

// one expected result word, unpacked from m_tdata / m_tuser
typedef struct packed {
    logic [pmpt_pkg::ID_W-1:0]    id;
    logic [pmpt_pkg::VALUE_W-1:0] value;
    logic [pmpt_pkg::PRIO_W-1:0]  prio;
    logic                         present;
    pmpt_pkg::status_t            status;
} table_reply_t;

class prio_table_scoreboard;
    logic [pmpt_pkg::VALUE_W-1:0] stored_value [pmpt_pkg::CAPACITY_DEF];
    logic [pmpt_pkg::PRIO_W-1:0]  stored_prio  [pmpt_pkg::CAPACITY_DEF];
    bit                           is_live      [pmpt_pkg::CAPACITY_DEF];
    int                           ids_issued;
    int                           live_count;
    int                           mismatches;
    table_reply_t                 pending_replies [$];

    function new();
        ids_issued = 0;
        live_count = 0;
        mismatches = 0;
        foreach (is_live[i]) is_live[i] = 1'b0;
    endfunction

    // one line per miss, every miss counted
    task report_mismatch(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    // work out the reply to an accepted command word and update the table copy
    function void note_command(logic [2:0] cmd, logic [pmpt_pkg::ID_W-1:0] id,
                               logic [pmpt_pkg::VALUE_W-1:0] value);
        table_reply_t r;
        int           best;
        r = '0;
        r.status = pmpt_pkg::ST_OK;
        best = -1;
        case (cmd)
            pmpt_pkg::CMD_ADD: begin
                if (ids_issued >= pmpt_pkg::CAPACITY_DEF) begin
                    r.status = pmpt_pkg::ST_FULL;
                end else begin
                    stored_value[ids_issued] = value;
                    stored_prio[ids_issued]  = '0;
                    is_live[ids_issued]      = 1'b1;
                    live_count++;
                    r.id    = ids_issued[pmpt_pkg::ID_W-1:0];
                    r.value = value;
                    ids_issued++;
                end
            end
            pmpt_pkg::CMD_PROMOTE: begin
                if (!is_live[id]) begin
                    r.status = pmpt_pkg::ST_NOT_LIVE;
                end else begin
                    if (stored_prio[id] != '1) stored_prio[id] = stored_prio[id] + 1'b1;
                    r.id    = id;
                    r.value = stored_value[id];
                    r.prio  = stored_prio[id];
                end
            end
            pmpt_pkg::CMD_PEEK, pmpt_pkg::CMD_POP: begin
                // scan from the top id down so a tie keeps the larger id
                for (int i = pmpt_pkg::CAPACITY_DEF - 1; i >= 0; i--) begin
                    if (is_live[i] && (best < 0 || stored_prio[i] > stored_prio[best])) best = i;
                end
                if (best < 0) begin
                    r.status = pmpt_pkg::ST_EMPTY;
                end else begin
                    r.id    = best[pmpt_pkg::ID_W-1:0];
                    r.value = stored_value[best];
                    r.prio  = stored_prio[best];
                    if (cmd == pmpt_pkg::CMD_POP) begin
                        is_live[best] = 1'b0;
                        live_count--;
                    end
                end
            end
            pmpt_pkg::CMD_LOOKUP: begin
                if (!is_live[id]) begin
                    r.status = pmpt_pkg::ST_NOT_LIVE;
                end else begin
                    r.id      = id;
                    r.value   = stored_value[id];
                    r.prio    = stored_prio[id];
                    r.present = 1'b1;
                end
            end
            default: ;
        endcase
        pending_replies = {pending_replies, r};
    endfunction

    task check_result(logic [55:0] tdata, logic [2:0] tuser);
        table_reply_t want;
        if (pending_replies.size() == 0) begin
            report_mismatch("result word with nothing pending");
            return;
        end
        want = pending_replies.pop_front();
        if (tdata[5:0] !== want.id)
            report_mismatch($sformatf("id got %0d want %0d", tdata[5:0], want.id));
        if (tdata[37:6] !== want.value)
            report_mismatch($sformatf("value got %h want %h", tdata[37:6], want.value));
        if (tdata[53:38] !== want.prio)
            report_mismatch($sformatf("priority got %0d want %0d", tdata[53:38], want.prio));
        if (tuser[0] !== want.present)
            report_mismatch($sformatf("present got %b want %b", tuser[0], want.present));
        if (tuser[2:1] !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", tuser[2:1], want.status));
    endtask
endclass

module promotable_max_priority_table_tb;

    typedef logic [pmpt_pkg::ID_W-1:0] word_id_t;

    // command codes the dut must treat as no-ops
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1950;
    localparam int HOLD_CYCLES  = 800;                              // long receiver stall
    localparam int SCAN_CYCLES  = pmpt_pkg::CAPACITY_DEF + 3;       // scan time of one word in the dut
    localparam int DRAIN_LIMIT  = 4 * SCAN_CYCLES + 2 * HOLD_CYCLES;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // item_id[5:0], item_value[37:6], zero pad
    logic [2:0]  s_tuser;   // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // result_id[5:0], result_value[37:6], result_priority[53:38]
    logic [2:0]  m_tuser;   // present[0], status[2:1]

    prio_table_scoreboard sb;

    // idle knobs shared by the sender and the receiver
    bit steady;             // set for the closing part: no idling at all
    bit hold_request;       // asks the receiver for one long stall
    bit hold_done;          // receiver has served the long stall
    int src_idle_pct;
    int sink_idle_pct;

    promotable_max_priority_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // entered and left just after a falling edge; a random idle burst may come first
    task send_word(input logic [2:0] cmd, input logic [pmpt_pkg::ID_W-1:0] id,
                   input logic [pmpt_pkg::VALUE_W-1:0] value);
        if (!steady && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {2'b00, value, id};
        s_tuser  = cmd;
        // outputs read right after the edge still hold their pre-edge value
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_command(cmd, id, value);
        @(negedge aclk);
    endtask

    // a live id when there is one, so promotes and lookups mostly hit
    function automatic logic [pmpt_pkg::ID_W-1:0] some_live_id();
        int start;
        int k;
        start = $urandom_range(0, pmpt_pkg::CAPACITY_DEF - 1);
        for (k = 0; k < pmpt_pkg::CAPACITY_DEF; k++) begin
            if (sb.is_live[(start + k) % pmpt_pkg::CAPACITY_DEF])
                return word_id_t'((start + k) % pmpt_pkg::CAPACITY_DEF);
        end
        return start[pmpt_pkg::ID_W-1:0];
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // receiver: random short stalls, plus one long counted stall on request
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_tready = 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge aclk);
                hold_done = 1'b1;
            end
            if (!steady && $urandom_range(0, 99) < sink_idle_pct) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    // stimulus
    initial begin
        int r;
        int waited;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        aresetn       = 1'b0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, unknown codes, ties, removed ids
        send_word(pmpt_pkg::CMD_PEEK, '0, '0);
        send_word(pmpt_pkg::CMD_POP, '0, '0);
        send_word(pmpt_pkg::CMD_LOOKUP, 6'd0, '0);
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd63, '0);
        send_word(CMD_SPARE_LO, 6'h2A, 32'hDEAD_BEEF);
        send_word(CMD_SPARE_MID, 6'h15, 32'h5555_AAAA);
        send_word(CMD_SPARE_HI, '1, '1);
        send_word(pmpt_pkg::CMD_ADD, '0, 32'h0000_0000);
        send_word(pmpt_pkg::CMD_ADD, '1, 32'hFFFF_FFFF);
        send_word(pmpt_pkg::CMD_ADD, '0, $urandom);
        send_word(pmpt_pkg::CMD_LOOKUP, 6'd1, '0);
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd1, '0);
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd1, '0);
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd0, '0);
        send_word(pmpt_pkg::CMD_PEEK, '0, '0);           // id 1 at priority 2
        send_word(pmpt_pkg::CMD_POP, '0, '0);
        send_word(pmpt_pkg::CMD_LOOKUP, 6'd1, '0);       // removed id
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd1, '0);      // removed id is rejected
        send_word(pmpt_pkg::CMD_PEEK, '0, '0);
        send_word(pmpt_pkg::CMD_PROMOTE, 6'd2, '0);
        send_word(pmpt_pkg::CMD_PEEK, '0, '0);           // tie at priority 1, larger id wins
        send_word(pmpt_pkg::CMD_LOOKUP, 6'd63, '0);      // never handed out
        send_word(pmpt_pkg::CMD_LOOKUP, 6'd2, '0);
        send_word(pmpt_pkg::CMD_POP, '0, '0);

        // random: adds are rare so the 64 ids last for the whole run
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) begin
                src_idle_pct  = pick_idle_pct();
                sink_idle_pct = pick_idle_pct();
            end
            if (n == 400) hold_request = 1'b1;   // sender keeps offering through the stall
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(pmpt_pkg::CMD_ADD, word_id_t'($urandom), $urandom);
            else if (r < 5)
                send_word(pmpt_pkg::CMD_POP, word_id_t'($urandom), $urandom);
            else if (r < 40)
                send_word(pmpt_pkg::CMD_PROMOTE,
                          ($urandom_range(0, 4) != 0) ? some_live_id() : word_id_t'($urandom),
                          $urandom);
            else if (r < 60)
                send_word(pmpt_pkg::CMD_PEEK, word_id_t'($urandom), $urandom);
            else if (r < 96)
                send_word(pmpt_pkg::CMD_LOOKUP,
                          ($urandom_range(0, 4) < 3) ? some_live_id() : word_id_t'($urandom),
                          $urandom);
            else
                send_word(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), word_id_t'($urandom),
                          $urandom);
        end

        // closing part without idling: fill the table, overflow it, drain it
        steady = 1'b1;
        while (sb.ids_issued < pmpt_pkg::CAPACITY_DEF)
            send_word(pmpt_pkg::CMD_ADD, word_id_t'($urandom), $urandom);
        repeat (2) send_word(pmpt_pkg::CMD_ADD, word_id_t'($urandom), $urandom);
        repeat (8) send_word(pmpt_pkg::CMD_PROMOTE, some_live_id(), $urandom);
        while (sb.live_count > 0) begin
            send_word(pmpt_pkg::CMD_POP, word_id_t'($urandom), $urandom);
            if ($urandom_range(0, 3) == 0)
                send_word(pmpt_pkg::CMD_LOOKUP, word_id_t'($urandom), $urandom);
        end
        send_word(pmpt_pkg::CMD_PEEK, word_id_t'($urandom), $urandom);
        send_word(pmpt_pkg::CMD_POP, word_id_t'($urandom), $urandom);
        send_word(pmpt_pkg::CMD_PROMOTE, word_id_t'($urandom), $urandom);
        send_word(pmpt_pkg::CMD_ADD, word_id_t'($urandom), $urandom);
        s_tvalid = 1'b0;

        // wait for every reply up to a limit, then keep watching for stray words
        waited = 0;
        while (sb.pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        while (sb.pending_replies.size() != 0) begin
            void'(sb.pending_replies.pop_front());
            sb.report_mismatch("reply never arrived");
        end
        repeat (3 * SCAN_CYCLES) @(posedge aclk);

        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog, several times the slowest correct run
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
